### hw/rtl/rtcp_pkg.sv
`default_nettype none

package rtcp_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned NumW = 2 * PixW;
  localparam int unsigned BitsPerStage = 2;
  localparam int unsigned DivStages = PixW / BitsPerStage;

  localparam logic [PixW-1:0] FullScale = 8'd255;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [NumW-1:0] num_t;

endpackage

`default_nettype wire

### hw/rtl/rtcp_div.sv
`default_nettype none

// Pipelined restoring divider, two quotient bits per stage.
// Requires num_i[15:8] < den_i and den_i != 0 (quotient fits in 8 bits).
module rtcp_div (
  input  wire logic          clk_i,
  input  wire rtcp_pkg::num_t num_i,
  input  wire rtcp_pkg::pix_t den_i,
  output rtcp_pkg::pix_t      quo_o
);

  localparam int unsigned W = rtcp_pkg::PixW;
  localparam int unsigned S = rtcp_pkg::DivStages;
  localparam int unsigned B = rtcp_pkg::BitsPerStage;

  function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic nb,
                                          input logic [W-1:0] den);
    logic [W:0] t;
    logic [W:0] diff;
    logic [W:0] res;
    t    = {rem, nb};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      res = {1'b1, diff[W-1:0]};
    end else begin
      res = {1'b0, t[W-1:0]};
    end
    return res;
  endfunction

  logic [W-1:0] rem_q [S];
  logic [W-1:0] lo_q  [S];
  logic [W-1:0] quo_q [S];
  logic [W-1:0] den_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [W-1:0] lo_in;
    logic [W-1:0] quo_in;
    logic [W-1:0] den_in;
    logic [W-1:0] rem_d;
    logic [W-1:0] lo_d;
    logic [W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i[rtcp_pkg::NumW-1:W];
      assign lo_in  = num_i[W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      logic [W:0] st;
      logic [W-1:0] r;
      logic [W-1:0] q;
      r = rem_in;
      q = quo_in;
      for (int unsigned j = 0; j < B; j++) begin
        st = div_step(r, lo_in[W-1-j], den_in);
        r  = st[W-1:0];
        q  = {q[W-2:0], st[W]};
      end
      rem_d = r;
      quo_d = q;
      lo_d  = lo_in << B;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      lo_q[k]  <= lo_d;
      quo_q[k] <= quo_d;
      den_q[k] <= den_in;
    end
  end

  assign quo_o = quo_q[S-1];

endmodule

`default_nettype wire

### hw/rtl/rgb_to_cmyk_pixel.sv
`default_nettype none

// RGB to CMYK pixel converter, 8 bits per component.
// Input: a pixel (red_i, green_i, blue_i) transfers at a rising edge with
// start high and busy low. busy is tied low: a pixel may enter every cycle.
// Output: valid_o strobes for exactly one cycle with cyan_o, magenta_o,
// yellow_o and black_o; the receiver takes it at the edge ending that cycle.
// black = 255 - max(r,g,b); each ink = floor((max - chan) * 255 / max),
// and a pure black pixel gives zero inks with black 255.
// Throughput: one pixel per cycle, set by the pipelined dividers
// (two quotient bits per stage, four stages) after a max/difference stage
// and a scale-by-255 stage.
// Reset clears only the valid pipeline; data in flight at reset is dropped.
// The receiver cannot stall, so nothing is ever held back.
module rgb_to_cmyk_pixel (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire rtcp_pkg::pix_t red_i,
  input  wire rtcp_pkg::pix_t green_i,
  input  wire rtcp_pkg::pix_t blue_i,
  output logic                valid_o,
  output rtcp_pkg::pix_t      cyan_o,
  output rtcp_pkg::pix_t      magenta_o,
  output rtcp_pkg::pix_t      yellow_o,
  output rtcp_pkg::pix_t      black_o
);

  localparam int unsigned S = rtcp_pkg::DivStages;
  localparam int unsigned Lat = S + 2;
  localparam int unsigned W = rtcp_pkg::PixW;

  assign busy = 1'b0;

  logic [Lat-1:0] vld_q;
  logic           take;
  assign take = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], take};
    end
  end

  // stage 1: max, differences, black
  rtcp_pkg::pix_t mx;
  rtcp_pkg::pix_t dr_q, dg_q, db_q, den1_q, blk1_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) begin
      mx = green_i;
    end
    if (blue_i > mx) begin
      mx = blue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= mx - red_i;
    dg_q   <= mx - green_i;
    db_q   <= mx - blue_i;
    den1_q <= (mx == '0) ? W'(1) : mx;
    blk1_q <= rtcp_pkg::FullScale - mx;
  end

  // stage 2: scale by 255
  function automatic rtcp_pkg::num_t scale(input rtcp_pkg::pix_t d);
    return {d, {W{1'b0}}} - {{W{1'b0}}, d};
  endfunction

  rtcp_pkg::num_t nr_q, ng_q, nb_q;
  rtcp_pkg::pix_t den2_q;
  rtcp_pkg::pix_t blk_q [S+1];

  always_ff @(posedge clk_i) begin
    nr_q     <= scale(dr_q);
    ng_q     <= scale(dg_q);
    nb_q     <= scale(db_q);
    den2_q   <= den1_q;
    blk_q[0] <= blk1_q;
    for (int unsigned k = 1; k <= S; k++) begin
      blk_q[k] <= blk_q[k-1];
    end
  end

  rtcp_div u_div_c (.clk_i(clk_i), .num_i(nr_q), .den_i(den2_q), .quo_o(cyan_o));
  rtcp_div u_div_m (.clk_i(clk_i), .num_i(ng_q), .den_i(den2_q), .quo_o(magenta_o));
  rtcp_div u_div_y (.clk_i(clk_i), .num_i(nb_q), .den_i(den2_q), .quo_o(yellow_o));

  assign black_o = blk_q[S];
  assign valid_o = vld_q[Lat-1];

endmodule

`default_nettype wire
